// ===== sv/adfp_pkg.sv =====
// Package of shared codes and character constants for the ASCII decimal field parser.
`default_nettype none

package adfp_pkg;

    // Field kinds: bit 1 marks a signed kind, bit 0 marks a 32-bit kind.
    localparam logic [1:0] KIND_U16 = 2'd0;
    localparam logic [1:0] KIND_U32 = 2'd1;
    localparam logic [1:0] KIND_S16 = 2'd2;
    localparam logic [1:0] KIND_S32 = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_BAD_END = 2'd2;

    // Characters of interest.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [31:0] MASK_16 = 32'h0000_FFFF;
    localparam logic [31:0] MASK_32 = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// ===== sv/adfp_if.sv =====
// Stream interfaces for the character requests and the parse results.
`default_nettype none

interface adfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic [1:0] kind;

    modport source (output valid, output char_in, output kind, input ready);
    modport sink   (input valid, input char_in, input kind, output ready);
endinterface

interface adfp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] number;
    logic [7:0]  ending_char;

    modport source (output valid, output status, output number, output ending_char,
                    input ready);
    modport sink   (input valid, input status, input number, input ending_char,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/ascii_decimal_field_parser.sv =====
// Top level of the ASCII decimal field parser: input stage, field state and result register.
//
// Usage:
//   i_req carries one character per request (char_in) plus the field kind
//   (kind: u16, u32, s16, s32), which is looked at only on the first
//   character of a field. Digits and, in signed kinds, minus signs are
//   consumed silently. The first other character ends the field and gives
//   exactly one result on o_rsp: status, number and the ending character.
//   Path: a character accepted on i_req is held in the input register,
//   and its result is then loaded into the result register, which drives
//   o_rsp.valid. Throughput: one request per cycle, except while a
//   terminating character waits for a held o_rsp; set by the accumulate
//   (times ten plus digit) on the field state register.
//   Stall: when o_rsp is held, the result register holds its value; a
//   digit or minus in the input register still advances, but a terminating
//   character waits there, and i_req.ready drops until the result is taken.
//   Reset (synchronous, active low): both stages empty, accumulator, minus
//   flag, started flag and held kind cleared; the next character opens a
//   new field.
`default_nettype none

module ascii_decimal_field_parser (
    input  wire               i_clk,
    input  wire               i_rst_n,
    adfp_in_if.sink           i_req,
    adfp_out_if.source        o_rsp
);

    // Input register.
    logic        r_s1_valid;
    logic [7:0]  r_char;
    logic [1:0]  r_kind;

    // Field state.
    logic [31:0] r_acc;
    logic        r_minus;
    logic        r_started;
    logic [1:0]  r_held_kind;

    // Result register.
    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [31:0] r_number;
    logic [7:0]  r_end_char;

    // Stage logic.
    logic [1:0]  s1_kind;
    logic [31:0] s1_mask;
    logic        s1_digit;
    logic        s1_minus;
    logic        s1_end;
    logic        s1_term;
    logic        out_free;
    logic        s1_adv;
    logic [31:0] n_acc;
    logic [1:0]  n_status;
    logic [31:0] n_number;

    assign s1_kind  = r_started ? r_held_kind : r_kind;
    assign s1_mask  = s1_kind[0] ? adfp_pkg::MASK_32 : adfp_pkg::MASK_16;
    assign s1_digit = (r_char >= adfp_pkg::CH_ZERO) && (r_char <= adfp_pkg::CH_NINE);
    assign s1_minus = s1_kind[1] && (r_char == adfp_pkg::CH_MINUS);
    assign s1_end   = !(s1_digit || s1_minus);
    assign s1_term  = (r_char == adfp_pkg::CH_CR) || (r_char == adfp_pkg::CH_LF)
                   || (r_char == adfp_pkg::CH_NUL) || (r_char == adfp_pkg::CH_COMMA)
                   || (r_char == adfp_pkg::CH_SPACE);

    // Result register can take a new result this cycle.
    assign out_free = !r_out_valid || o_rsp.ready;
    // Consumed characters always advance; a terminator needs room downstream.
    assign s1_adv   = r_s1_valid && (!s1_end || out_free);

    assign i_req.ready = !r_s1_valid || s1_adv;

    // acc * 10 + digit as two shifts and adds, wrapped to the kind's width.
    assign n_acc = ({r_acc[28:0], 3'b000} + {r_acc[30:0], 1'b0}
                  + {28'd0, r_char[3:0]}) & s1_mask;

    always_comb begin
        n_status = adfp_pkg::ST_OK;
        n_number = 32'd0;
        if (!r_started) begin
            n_status = adfp_pkg::ST_EMPTY;
        end else if (!s1_term) begin
            n_status = adfp_pkg::ST_BAD_END;
        end else if (r_minus) begin
            n_number = (32'd0 - r_acc) & s1_mask;
        end else begin
            n_number = r_acc;
        end
    end

    // Input register: take a request whenever the stage is empty or moving on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
        if (i_req.valid && i_req.ready) begin
            r_char <= i_req.char_in;
            r_kind <= i_req.kind;
        end
    end

    // Field state: advance on consumed characters, clear when a field ends.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= 32'd0;
            r_minus     <= 1'b0;
            r_started   <= 1'b0;
            r_held_kind <= adfp_pkg::KIND_U16;
        end else if (s1_adv) begin
            if (s1_end) begin
                r_acc       <= 32'd0;
                r_minus     <= 1'b0;
                r_started   <= 1'b0;
                r_held_kind <= adfp_pkg::KIND_U16;
            end else begin
                if (s1_digit) begin
                    r_acc <= n_acc;
                end else begin
                    r_minus <= 1'b1;
                end
                r_started   <= 1'b1;
                r_held_kind <= s1_kind;
            end
        end
    end

    // Result register: load on a field end, drop once the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid && s1_end;
        end
        if (out_free && r_s1_valid && s1_end) begin
            r_status   <= n_status;
            r_number   <= n_number;
            r_end_char <= r_char;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.number      = r_number;
    assign o_rsp.ending_char = r_end_char;

    // A field end leaves the field state cleared.
    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_end && s1_adv) |=> (!r_started && !r_minus && r_acc == 32'd0))
        else $error("field state not cleared after field end");

    // A 16-bit field never carries bits above the low half.
    a_narrow_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_started && !r_held_kind[0]) |-> (r_acc[31:16] == 16'd0))
        else $error("16-bit accumulator has upper bits set");

    // Error results carry a zero number and a defined status.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != adfp_pkg::ST_OK) |->
            (r_number == 32'd0
             && (r_status == adfp_pkg::ST_EMPTY || r_status == adfp_pkg::ST_BAD_END)))
        else $error("bad error result");

    // A field end that finds room downstream loads a result.
    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_free && r_s1_valid && s1_end) |=> r_out_valid)
        else $error("field end did not produce a result");

endmodule

`default_nettype wire
